// File: sv/ple_pkg.sv
// shared types and constants of the positional list engine
package ple_pkg;

  // default list capacity
  localparam int DEPTH_DEF = 32;

  // request codes of the op field
  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_APPEND     = 2'd1;
  localparam logic [1:0] OP_DELETE     = 2'd2;

  // one request
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
    logic [7:0]         position;
  } in_t;

  // one result
  typedef struct packed {
    logic signed [31:0] element;
    logic               is_last;
    logic               list_empty;
    logic               full_refused;
  } out_t;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_PUSH   = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_ROTATE = 3'd4
  } cell_cmd_e;

  // control group from the sequencer to the cells
  typedef struct packed {
    cell_cmd_e          cmd;
    logic [7:0]         count;
    logic [7:0]         pos;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

// File: sv/ple_cell.sv
// one list cell: holds one entry and trades it with its neighbors
module ple_cell #(
  parameter int IDX = 0
) (
  input  logic                    clk_i,
  input  ple_pkg::cell_ctl_t      ctl_i,
  input  logic signed [31:0]      left_i,
  input  logic signed [31:0]      right_i,
  input  logic signed [31:0]      head_i,
  output logic signed [31:0]      data_o
);

  localparam logic [7:0] IDX_B = 8'(IDX);
  localparam logic [7:0] NXT_B = 8'(IDX + 1);

  logic signed [31:0] data_q, data_d;

  // next entry value for the broadcast command
  always_comb begin
    data_d = data_q;
    case (ctl_i.cmd)
      ple_pkg::CMD_PUSH: begin
        data_d = left_i;
      end
      ple_pkg::CMD_APPEND: begin
        if (IDX_B == ctl_i.count) data_d = ctl_i.value;
      end
      ple_pkg::CMD_DELETE: begin
        if (IDX_B >= ctl_i.pos) data_d = right_i;
      end
      ple_pkg::CMD_ROTATE: begin
        // front entry wraps to the last occupied cell
        if (NXT_B == ctl_i.count) begin
          data_d = head_i;
        end else if (NXT_B < ctl_i.count) begin
          data_d = right_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: sv/positional_list_engine.sv
// positional list engine top level: sequencer and row of list cells
//
// Usage:
//   in channel (in_valid_i / in_stall_o / in_data_i) takes one request:
//   insert at front, append at back, or delete at a position.
//   out channel (out_valid_o / out_stall_i / out_data_o) returns the whole
//   list after that request, front first, one transfer per entry, with
//   is_last on the final one. An empty list gives one transfer flagged
//   list_empty. A refused insert sets full_refused on every transfer.
// Update and output order:
//   the list update happens at the edge that takes the request; the first
//   result is valid the next cycle. Results leave the front cell and the
//   cell row rotates one place per output transfer.
// Stall and reset:
//   while out_stall_i is high the current result holds and the row stays
//   put; in_stall_o stays high until the last result of a request has gone.
//   Reset empties the list; entry contents are left as they are.
module positional_list_engine #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ple_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ple_pkg::out_t   out_data_o
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic               refused_q, refused_d;
  logic               in_xfer, out_xfer;
  logic               full, empty, last;
  logic               is_ins;
  ple_pkg::cell_ctl_t ctl;
  logic signed [31:0] cell_data [DEPTH];

  // handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_o && !out_stall_i;

  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);
  assign last   = empty || (idx_q == (count_q - CW'(1)));
  assign is_ins = (in_data_i.op == ple_pkg::OP_PUSH_FRONT) ||
                  (in_data_i.op == ple_pkg::OP_APPEND);

  // cell command and list length update
  always_comb begin
    ctl.cmd   = ple_pkg::CMD_HOLD;
    ctl.count = 8'(count_q);
    ctl.pos   = in_data_i.position;
    ctl.value = in_data_i.value;
    count_d   = count_q;
    if (in_xfer) begin
      case (in_data_i.op)
        ple_pkg::OP_PUSH_FRONT: begin
          if (!full) begin
            ctl.cmd = ple_pkg::CMD_PUSH;
            count_d = count_q + CW'(1);
          end
        end
        ple_pkg::OP_APPEND: begin
          if (!full) begin
            ctl.cmd = ple_pkg::CMD_APPEND;
            count_d = count_q + CW'(1);
          end
        end
        ple_pkg::OP_DELETE: begin
          if (in_data_i.position < 8'(count_q)) begin
            ctl.cmd = ple_pkg::CMD_DELETE;
            count_d = count_q - CW'(1);
          end
        end
        default: begin
          ctl.cmd = ple_pkg::CMD_HOLD;
        end
      endcase
    end else if (out_xfer && !empty) begin
      ctl.cmd = ple_pkg::CMD_ROTATE;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    refused_d = refused_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d   = ST_EMIT;
          idx_d     = '0;
          refused_d = is_ins && full;
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          idx_d = idx_q + CW'(1);
          if (last) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      refused_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      refused_q <= refused_d;
    end
  end

  // row of cells, cell 0 is the list front
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = ctl.value;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_lastc
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    ple_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .left_i (left_w),
      .right_i(right_w),
      .head_i (cell_data[0]),
      .data_o (cell_data[g])
    );
  end

  // result from the front cell
  assign out_data_o.element      = empty ? 32'sd0 : cell_data[0];
  assign out_data_o.is_last      = last;
  assign out_data_o.list_empty   = empty;
  assign out_data_o.full_refused = refused_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list length beyond capacity");

  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (empty || idx_q < count_q))
    else $error("output index past list end");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last) |=> !in_stall_o)
    else $error("engine busy after last result");

  a_req_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("request produced no result");

  a_refused_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && is_ins && full) |=> (count_q == $past(count_q) && refused_q))
    else $error("refused insert changed the list");

endmodule
